// File: hdl/etsm_pkg.sv
// Shared types, constants and helpers for the escape-time set membership core.
// Depends on nothing; every other file of the core uses it.
package etsm_pkg;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int STEP_W    = 29;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 2;

    // Parameter defaults
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int ITER_BITS_DEF  = 16;

    // Register reset values
    localparam int unsigned          MAX_ITER_RST   = 100;
    localparam logic [STEP_W-1:0]    PIXEL_STEP_RST = STEP_W'(536871);
    localparam logic signed [DATA_W-1:0] ORIGIN_RST = -32'sd603979776;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM  = 2'd3;

    // Saturation bounds of a data word, held in product width
    localparam logic signed [PROD_W-1:0] SAT_HI = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam logic signed [PROD_W-1:0] SAT_LO = -(64'sd1 <<< (DATA_W - 1));

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture pixel offsets
        logic setup;  // form c, clear z
        logic mul;    // capture squares and cross product
        logic upd;    // replace z with z^2 + c
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic escape; // |z|^2 > 4 on the captured products
    } t_dp_sts;

    // Clamp a wide signed value to the signed data range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/etsm_if.sv
// Handshake channels of the escape-time core: pixel requests, results, register writes.
// Depends on etsm_pkg for widths and defaults.
interface etsm_pix_if #(
    parameter int COORD_BITS = etsm_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;

    modport source (output valid, output pix_x, output pix_y, input ready);
    modport sink   (input valid, input pix_x, input pix_y, output ready);
endinterface

interface etsm_res_if ();
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

interface etsm_cfg_if ();
    logic                                valid;
    logic                                ready;
    logic [etsm_pkg::CFG_IDX_W-1:0]      idx;
    logic [etsm_pkg::DATA_W-1:0]         data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// File: hdl/etsm_cfg.sv
// Configuration register file of the escape-time core.
// Depends on etsm_pkg and etsm_cfg_if.
module etsm_cfg #(
    parameter int ITER_BITS = etsm_pkg::ITER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    etsm_cfg_if.sink                            i_cfg,
    output logic [ITER_BITS-1:0]                o_max_iter,
    output logic [etsm_pkg::STEP_W-1:0]         o_pixel_step,
    output logic signed [etsm_pkg::DATA_W-1:0]  o_origin_re,
    output logic signed [etsm_pkg::DATA_W-1:0]  o_origin_im
);
    import etsm_pkg::*;

    logic [ITER_BITS-1:0]        r_max_iter;
    logic [STEP_W-1:0]           r_pixel_step;
    logic signed [DATA_W-1:0]    r_origin_re;
    logic signed [DATA_W-1:0]    r_origin_im;

    // Take every write request at once
    assign i_cfg.ready = 1'b1;

    // Decode writes by register index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= ITER_BITS'(MAX_ITER_RST);
            r_pixel_step <= PIXEL_STEP_RST;
            r_origin_re  <= ORIGIN_RST;
            r_origin_im  <= ORIGIN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                CFG_MAX_ITER:   r_max_iter   <= i_cfg.data[ITER_BITS-1:0];
                CFG_PIXEL_STEP: r_pixel_step <= i_cfg.data[STEP_W-1:0];
                CFG_ORIGIN_RE:  r_origin_re  <= $signed(i_cfg.data);
                CFG_ORIGIN_IM:  r_origin_im  <= $signed(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    assign o_max_iter   = r_max_iter;
    assign o_pixel_step = r_pixel_step;
    assign o_origin_re  = r_origin_re;
    assign o_origin_im  = r_origin_im;

endmodule

// File: hdl/etsm_dp.sv
// Datapath of the escape-time core: point setup, complex squaring, escape test.
// Depends on etsm_pkg; driven by commands from etsm_ctrl.
module etsm_dp #(
    parameter int COORD_BITS = etsm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = etsm_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [COORD_BITS-1:0]               i_pix_x,
    input  logic [COORD_BITS-1:0]               i_pix_y,
    input  logic [etsm_pkg::STEP_W-1:0]         i_pixel_step,
    input  logic signed [etsm_pkg::DATA_W-1:0]  i_origin_re,
    input  logic signed [etsm_pkg::DATA_W-1:0]  i_origin_im,
    input  etsm_pkg::t_dp_cmd                   i_cmd,
    output etsm_pkg::t_dp_sts                   o_sts
);
    import etsm_pkg::*;

    localparam int OFF_W = COORD_BITS + STEP_W;
    localparam logic [PROD_W-1:0] LIMIT = 64'd1 << (2 * FRAC_BITS + 2);

    logic [OFF_W-1:0]            r_off_re;
    logic [OFF_W-1:0]            r_off_im;
    logic signed [DATA_W-1:0]    r_c_re;
    logic signed [DATA_W-1:0]    r_c_im;
    logic signed [DATA_W-1:0]    r_re;
    logic signed [DATA_W-1:0]    r_im;
    logic signed [PROD_W-1:0]    r_sq_re;
    logic signed [PROD_W-1:0]    r_sq_im;
    logic signed [PROD_W-1:0]    r_cross;

    logic signed [PROD_W-1:0]    w_sum_re;
    logic signed [PROD_W-1:0]    w_sum_im;
    logic signed [PROD_W-1:0]    w_sq_re;
    logic signed [PROD_W-1:0]    w_sq_im;
    logic signed [PROD_W-1:0]    w_cross;
    logic [PROD_W-1:0]           w_mag;
    logic signed [PROD_W-1:0]    w_diff;
    logic signed [PROD_W-1:0]    w_nre;
    logic signed [PROD_W-1:0]    w_nim;

    // Offset of the point from the origin
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_off_re <= OFF_W'(i_pix_x) * OFF_W'(i_pixel_step);
            r_off_im <= OFF_W'(i_pix_y) * OFF_W'(i_pixel_step);
        end
    end

    // c = origin + offset, clamped
    assign w_sum_re = PROD_W'(i_origin_re) + PROD_W'($signed({1'b0, r_off_re}));
    assign w_sum_im = PROD_W'(i_origin_im) + PROD_W'($signed({1'b0, r_off_im}));

    // Products of the current z
    assign w_sq_re = r_re * r_re;
    assign w_sq_im = r_im * r_im;
    assign w_cross = r_re * r_im;

    // Escape test and update on the registered products
    assign w_mag  = $unsigned(r_sq_re) + $unsigned(r_sq_im);
    assign w_diff = r_sq_re - r_sq_im;
    assign w_nre  = (w_diff >>> FRAC_BITS) + PROD_W'(r_c_re);
    assign w_nim  = (r_cross >>> (FRAC_BITS - 1)) + PROD_W'(r_c_im);

    assign o_sts.escape = (w_mag > LIMIT);

    // Hold c and z; advance z on update
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_c_re <= sat_data(w_sum_re);
            r_c_im <= sat_data(w_sum_im);
            r_re   <= '0;
            r_im   <= '0;
        end else if (i_cmd.upd) begin
            r_re   <= sat_data(w_nre);
            r_im   <= sat_data(w_nim);
        end
        if (i_cmd.mul) begin
            r_sq_re <= w_sq_re;
            r_sq_im <= w_sq_im;
            r_cross <= w_cross;
        end
    end

endmodule

// File: hdl/etsm_ctrl.sv
// Controller of the escape-time core: round counting, sequencing, result register.
// Depends on etsm_pkg; commands etsm_dp.
module etsm_ctrl #(
    parameter int ITER_BITS = etsm_pkg::ITER_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_out_inside,
    input  logic [ITER_BITS-1:0]    i_max_iter,
    output etsm_pkg::t_dp_cmd       o_cmd,
    input  etsm_pkg::t_dp_sts       i_sts
);
    import etsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_UPD,
        S_HOLD
    } t_state;

    t_state                 r_state, n_state;
    logic [ITER_BITS-1:0]   r_k, n_k;
    logic                   r_pend, n_pend;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_inside, n_out_inside;
    logic                   w_out_free;
    logic                   w_fin;
    logic                   w_fin_inside;
    logic [ITER_BITS-1:0]   w_k_inc;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_k_inc    = r_k + 1'b1;
    assign o_in_ready = (r_state == S_IDLE);

    // Commands per state
    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.setup = (r_state == S_SETUP);
        o_cmd.mul   = (r_state == S_MUL);
        o_cmd.upd   = (r_state == S_UPD) && !i_sts.escape;
    end

    // Next state, counter and result
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_pend       = r_pend;
        w_fin        = 1'b0;
        w_fin_inside = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_k = '0;
                if (i_max_iter == '0) begin
                    w_fin        = 1'b1;
                    w_fin_inside = 1'b1;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_sts.escape) begin
                    w_fin        = 1'b1;
                    w_fin_inside = 1'b0;
                end else if (w_k_inc == i_max_iter) begin
                    w_fin        = 1'b1;
                    w_fin_inside = 1'b1;
                end else begin
                    n_k     = w_k_inc;
                    n_state = S_MUL;
                end
            end
            S_HOLD: begin
                w_fin        = 1'b1;
                w_fin_inside = r_pend;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Drop a taken result, then load a finished one or park it
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_inside = r_out_inside;
        if (w_fin) begin
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_out_inside = w_fin_inside;
                n_state      = S_IDLE;
            end else begin
                n_pend  = w_fin_inside;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_inside <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_k          <= n_k;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
            r_out_inside <= n_out_inside;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_inside = r_out_inside;

`ifndef SYNTHESIS
    // The round counter stays below the round limit inside the loop
    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_UPD) |-> (r_k < i_max_iter))
        else $error("round counter reached the round limit inside the loop");

    // An accepted request goes to point setup
    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_SETUP))
        else $error("accepted request did not enter setup");

    // An escape with a free output register reports outside next cycle
    a_escape_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && i_sts.escape && w_out_free)
        |=> (r_out_valid && !r_out_inside && r_state == S_IDLE))
        else $error("escape did not report outside");

    // Zero rounds report inside without entering the loop
    a_zero_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP && i_max_iter == '0 && w_out_free)
        |=> (r_out_valid && r_out_inside))
        else $error("zero rounds did not report inside");
`endif

endmodule

// File: hdl/escape_time_set_membership_core.sv
// Top level of the escape-time set membership core.
// Depends on etsm_pkg, etsm_if, etsm_cfg, etsm_dp and etsm_ctrl.

// Tests one pixel at a time for membership in the Mandelbrot set. A request
// carries pixel column and row; the core forms c = origin + coordinate * step
// in signed Q4.28 (FRAC_BITS fraction bits), iterates z = z^2 + c from zero and
// returns inside_res = 1 when |z|^2 > 4 never fires within max_iter rounds.
// A point passes through request capture and point setup, then each round has a
// multiply step (the three 32x32 products) and an update step (the escape test
// and the saturated update); an inside point runs all max_iter rounds, and a
// point that escapes early runs fewer. The next request is taken in the cycle
// after the result is loaded, while that result still waits in the output
// register. The user must write registers over the configuration channel only
// between points; the core does not enforce it. All four indexes name a register.
module escape_time_set_membership_core #(
    parameter int COORD_BITS = etsm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = etsm_pkg::FRAC_BITS_DEF,
    parameter int ITER_BITS  = etsm_pkg::ITER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    etsm_pix_if.sink    i_pix,
    etsm_res_if.source  o_res,
    etsm_cfg_if.sink    i_cfg
);
    import etsm_pkg::*;

    logic [ITER_BITS-1:0]       w_max_iter;
    logic [STEP_W-1:0]          w_pixel_step;
    logic signed [DATA_W-1:0]   w_origin_re;
    logic signed [DATA_W-1:0]   w_origin_im;
    t_dp_cmd                    w_cmd;
    t_dp_sts                    w_sts;
    logic                       w_in_ready;
    logic                       w_out_valid;
    logic                       w_out_inside;

    // Register file
    etsm_cfg #(
        .ITER_BITS (ITER_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_max_iter   (w_max_iter),
        .o_pixel_step (w_pixel_step),
        .o_origin_re  (w_origin_re),
        .o_origin_im  (w_origin_im)
    );

    // Arithmetic
    etsm_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_pix_x      (i_pix.pix_x),
        .i_pix_y      (i_pix.pix_y),
        .i_pixel_step (w_pixel_step),
        .i_origin_re  (w_origin_re),
        .i_origin_im  (w_origin_im),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts)
    );

    // Sequencing and result register
    etsm_ctrl #(
        .ITER_BITS (ITER_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_pix.valid),
        .o_in_ready   (w_in_ready),
        .o_out_valid  (w_out_valid),
        .i_out_ready  (o_res.ready),
        .o_out_inside (w_out_inside),
        .i_max_iter   (w_max_iter),
        .o_cmd        (w_cmd),
        .i_sts        (w_sts)
    );

    assign i_pix.ready      = w_in_ready;
    assign o_res.valid      = w_out_valid;
    assign o_res.inside_res = w_out_inside;

endmodule

// File: tb/etsm_membership_checker.sv
// Scoreboard for the escape-time set membership core: watches the pixel, result
// and register channels, predicts inside/outside per pixel and compares.
// Depends on etsm_pkg and the channel interfaces in etsm_if.
module etsm_membership_checker #(
    parameter int COORD_BITS = etsm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = etsm_pkg::FRAC_BITS_DEF,
    parameter int ITER_BITS  = etsm_pkg::ITER_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    etsm_pix_if  i_pix,
    etsm_res_if  i_res,
    etsm_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import etsm_pkg::*;

    localparam logic [63:0]        ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);
    localparam logic signed [63:0] WORD_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN     = -64'sd2147483648;
    localparam int                 MAX_REPORTS  = 10;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  in_set;
    } t_pixel_verdict;

    // Shadow copy of the core's registers
    logic [ITER_BITS-1:0]       rounds_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [DATA_W-1:0]   org_re_reg;
    logic signed [DATA_W-1:0]   org_im_reg;

    t_pixel_verdict verdict_q[$];
    t_pixel_verdict entry;
    int             fail_cnt;
    int             report_cnt;

    // Clamp to the signed 32-bit range
    function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
        if (v > WORD_MAX) begin
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // Iterate z = z^2 + c from zero; 1 when |z|^2 > 4 never fires
    function automatic logic point_stays_bounded(input logic [COORD_BITS-1:0] px,
                                                 input logic [COORD_BITS-1:0] py);
        logic signed [63:0] px64;
        logic signed [63:0] py64;
        logic signed [63:0] step64;
        logic signed [63:0] ore;
        logic signed [63:0] oim;
        logic signed [63:0] c_re;
        logic signed [63:0] c_im;
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic signed [63:0] diff;
        logic signed [63:0] xprod;
        logic signed [63:0] nre;
        logic signed [63:0] nim;
        logic [63:0]        are;
        logic [63:0]        aim;
        logic [63:0]        sr;
        logic [63:0]        si;
        logic               bounded;
        int                 k;
        px64    = {{(64-COORD_BITS){1'b0}}, px};
        py64    = {{(64-COORD_BITS){1'b0}}, py};
        step64  = {{(64-STEP_W){1'b0}}, step_reg};
        ore     = org_re_reg;
        oim     = org_im_reg;
        c_re    = clamp_word(ore + px64 * step64);
        c_im    = clamp_word(oim + py64 * step64);
        re      = '0;
        im      = '0;
        bounded = 1'b1;
        for (k = 0; k < int'(rounds_reg); k++) begin
            are = (re < 0) ? -re : re;
            aim = (im < 0) ? -im : im;
            sr  = are * are;
            si  = aim * aim;
            // Test first; the last update is never tested
            if (sr + si > ESCAPE_BOUND) begin
                bounded = 1'b0;
                break;
            end
            diff  = $signed(sr) - $signed(si);
            xprod = re * im;
            nre   = clamp_word((diff >>> FRAC_BITS) + c_re);
            nim   = clamp_word((xprod >>> (FRAC_BITS - 1)) + c_im);
            re    = nre;
            im    = nim;
        end
        return bounded;
    endfunction

    // Track register writes, queue predictions, compare results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rounds_reg = ITER_BITS'(MAX_ITER_RST);
            step_reg   = PIXEL_STEP_RST;
            org_re_reg = ORIGIN_RST;
            org_im_reg = ORIGIN_RST;
            verdict_q.delete();
            fail_cnt   = 0;
            report_cnt = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.idx)
                    CFG_MAX_ITER: begin
                        rounds_reg = i_cfg.data[ITER_BITS-1:0];
                    end
                    CFG_PIXEL_STEP: begin
                        step_reg = i_cfg.data[STEP_W-1:0];
                    end
                    CFG_ORIGIN_RE: begin
                        org_re_reg = i_cfg.data;
                    end
                    CFG_ORIGIN_IM: begin
                        org_im_reg = i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end

            // Match the result before queueing a new request of the same edge
            if (i_res.valid && i_res.ready) begin
                if (verdict_q.size() == 0) begin
                    fail_cnt++;
                    if (report_cnt < MAX_REPORTS) begin
                        report_cnt++;
                        $display("mismatch: result inside_res=%0b with no pixel pending",
                                 i_res.inside_res);
                    end
                end else begin
                    entry = verdict_q.pop_front();
                    if (entry.in_set !== i_res.inside_res) begin
                        fail_cnt++;
                        if (report_cnt < MAX_REPORTS) begin
                            report_cnt++;
                            $display("mismatch: pixel (%0d,%0d) inside_res expected %0b got %0b",
                                     entry.x, entry.y, entry.in_set, i_res.inside_res);
                        end
                    end
                end
            end

            if (i_pix.valid && i_pix.ready) begin
                entry.x      = i_pix.pix_x;
                entry.y      = i_pix.pix_y;
                entry.in_set = point_stays_bounded(i_pix.pix_x, i_pix.pix_y);
                verdict_q.push_back(entry);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= verdict_q.size();
    end

endmodule

// File: tb/tb_escape_time_set_membership_core.sv
// Testbench top for escape_time_set_membership_core: drives pixel requests and
// register writes, stalls the result side, and reports the verdict.
// Depends on etsm_pkg, etsm_if, the core and etsm_membership_checker.
module tb_escape_time_set_membership_core;
    import etsm_pkg::*;

    localparam int COORD_BITS     = COORD_BITS_DEF;
    localparam int ONE_Q          = 1 << FRAC_BITS_DEF;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 600000;
    localparam int PHASE_ITEMS    = 205;
    localparam int RANDOM_PHASES  = 9;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   tx_fast;
    bit   rx_fast;
    int   hold_requests;
    int   holds_served;

    etsm_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();
    etsm_res_if res_ch ();
    etsm_cfg_if cfg_ch ();

    escape_time_set_membership_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    etsm_membership_checker #(.COORD_BITS(COORD_BITS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offer one pixel request after a random gap (none when tx_fast is set); return once it is taken
    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pix_x <= x;
        pix_ch.pix_y <= y;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    // Write one register, leaving valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Load all four registers; only called with the core idle
    task automatic set_window(input logic [DATA_W-1:0] rounds, input logic [DATA_W-1:0] step,
                              input logic [DATA_W-1:0] ore, input logic [DATA_W-1:0] oim);
        write_reg(CFG_MAX_ITER, rounds);
        write_reg(CFG_PIXEL_STEP, step);
        write_reg(CFG_ORIGIN_RE, ore);
        write_reg(CFG_ORIGIN_IM, oim);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid and wait until every result has come back
    task automatic finish_phase();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: random stalls, no-stall stretches, one long hold-off
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            if (hold_requests != holds_served) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_served++;
            end
            stall = rx_fast ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // End the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
                     (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int          phase;
        bit          wild;
        int          rounds;
        int          org_re;
        int          org_im;
        logic [31:0] step;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        tx_fast       = 1'b0;
        rx_fast       = 1'b0;
        hold_requests = 0;
        holds_served  = 0;
        pix_ch.valid  = 1'b0;
        pix_ch.pix_x  = '0;
        pix_ch.pix_y  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.idx    = '0;
        cfg_ch.data   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window: corners, a point near zero, a point on the real axis
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1125, 12'd1125);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd1000, 12'd1125);
        finish_phase();

        // Zero rounds, upper data bits set: always inside
        set_window(32'hFFFF_0000, 32'(PIXEL_STEP_RST), ORIGIN_RST, ORIGIN_RST);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        finish_phase();

        // Zero step at the origin: every pixel is c = 0
        set_window(32'hABCD_0014, 32'hE000_0000, 32'd0, 32'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        finish_phase();

        // c = -2 sits exactly on |z|^2 = 4 and never escapes
        set_window(32'd50, 32'd0, 32'(-2 * ONE_Q), 32'd0);
        send_pixel(12'd7, 12'd9);
        finish_phase();

        // c = 2 and c = 2i touch the bound once, then escape
        set_window(32'd50, 32'd0, 32'(2 * ONE_Q), 32'd0);
        send_pixel(12'd0, 12'd0);
        finish_phase();
        set_window(32'd50, 32'd0, 32'd0, 32'(2 * ONE_Q));
        send_pixel(12'd5, 12'd5);
        finish_phase();

        // Saturating points at the origin extremes
        set_window(32'd8, 32'(ONE_Q), 32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd0);
        finish_phase();
        set_window(32'd8, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd1);
        finish_phase();

        // Largest round count: one full inside run, two fast escapes
        set_window(32'hFFFF_FFFF, 32'(ONE_Q), 32'd0, 32'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd3, 12'd2);
        finish_phase();

        // Hold the result side while requests keep coming
        set_window(32'd30, 32'h0004_0000, ORIGIN_RST, 32'(-(ONE_Q * 2)));
        hold_requests++;
        tx_fast = 1'b1;
        rx_fast = 1'b0;
        repeat (40) send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
        finish_phase();

        // Random windows: mostly over the set, some arbitrary
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wild   = ($urandom_range(0, 3) == 0);
            rounds = (phase == 4) ? $urandom_range(100, 250) : $urandom_range(0, 48);
            if (wild) begin
                step   = $urandom;
                org_re = $urandom;
                org_im = $urandom;
            end else begin
                step   = $urandom_range(1 << 16, 1 << 19);
                org_re = int'(ORIGIN_RST) + int'($urandom_range(0, ONE_Q)) - (ONE_Q / 2);
                org_im = -(ONE_Q * 2) + int'($urandom_range(0, ONE_Q)) - (ONE_Q / 2);
            end
            set_window({16'($urandom), 16'(rounds)}, step, 32'(org_re), 32'(org_im));
            tx_fast = (phase % 3 == 2);
            rx_fast = tx_fast;
            repeat (PHASE_ITEMS) send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
            finish_phase();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
